/* sv/lls_pkg.sv */
`timescale 1ns / 1ps
package lls_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned LOAD_W = 32;
  localparam int unsigned CFG_W  = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic write;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic has_job;
    logic batch_last;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

/* sv/lls_job_if.sv */
`timescale 1ns / 1ps
interface lls_job_if;
  logic                       valid;
  logic                       ready;
  logic [lls_pkg::TIME_W-1:0] job_time;
  logic                       has_job;
  logic                       batch_last;

  modport source (output valid, job_time, has_job, batch_last, input ready);
  modport sink (input valid, job_time, has_job, batch_last, output ready);
endinterface

/* sv/lls_result_if.sv */
`timescale 1ns / 1ps
interface lls_result_if;
  logic                       valid;
  logic                       ready;
  logic [lls_pkg::LOAD_W-1:0] completion_time;

  modport source (output valid, completion_time, input ready);
  modport sink (input valid, completion_time, output ready);
endinterface

/* sv/lls_ctrl.sv */
`timescale 1ns / 1ps
module lls_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  lls_pkg::status_t status,
  output lls_pkg::cmd_t    cmd
);

  lls_pkg::state_t state;
  lls_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lls_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    job_ready  = 1'b0;
    unique case (state)
      lls_pkg::ST_IDLE: begin
        job_ready = !rst;
        if (job_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = lls_pkg::ST_SCAN;
        end
      end
      lls_pkg::ST_SCAN: begin
        if (!status.has_job) begin
          state_next = status.batch_last ? lls_pkg::ST_DONE : lls_pkg::ST_IDLE;
        end else if (status.scan_done) begin
          state_next = lls_pkg::ST_WRITE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      lls_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = status.batch_last ? lls_pkg::ST_DONE : lls_pkg::ST_IDLE;
      end
      lls_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = lls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lls_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> (state == lls_pkg::ST_IDLE))
    else $error("job taken outside idle");
  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> $past(state) == lls_pkg::ST_SCAN)
    else $error("write without a finished scan");
`endif

endmodule

/* sv/lls_datapath.sv */
`timescale 1ns / 1ps
module lls_datapath #(
  parameter int unsigned MAX_SERVERS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lls_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [lls_pkg::TIME_W-1:0]  in_job_time,
  input  logic                        in_has_job,
  input  logic                        in_batch_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lls_pkg::LOAD_W-1:0]  out_completion_time,
  input  lls_pkg::cmd_t               cmd,
  output lls_pkg::status_t            status
);

  localparam int unsigned IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SERVERS + 1);

  logic [lls_pkg::LOAD_W-1:0] mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0]     vld;
  logic [lls_pkg::CFG_W-1:0]  server_count;
  logic [lls_pkg::TIME_W-1:0] job_time;
  logic                       has_job;
  logic                       batch_last;
  logic [CNT_W-1:0]           rd_idx;
  logic [IDX_W-1:0]           rd_idx_d;
  logic                       rd_pend;
  logic [lls_pkg::LOAD_W-1:0] rd_data;
  logic                       rd_vld;
  logic [lls_pkg::LOAD_W-1:0] best_val;
  logic [IDX_W-1:0]           best_idx;
  logic [lls_pkg::LOAD_W-1:0] max_load;
  logic [31:0]                cnt_wide;
  logic [CNT_W-1:0]           n_eff;
  logic                       rd_issue;
  logic [lls_pkg::LOAD_W-1:0] cand;
  logic [lls_pkg::LOAD_W:0]   sum;
  logic [lls_pkg::LOAD_W-1:0] sat;

  always_comb begin
    if (server_count == '0) begin
      cnt_wide = 32'd1;
    end else if (32'(server_count) > 32'(MAX_SERVERS)) begin
      cnt_wide = 32'(MAX_SERVERS);
    end else begin
      cnt_wide = 32'(server_count);
    end
  end

  assign n_eff    = cnt_wide[CNT_W-1:0];
  assign rd_issue = cmd.scan && (rd_idx != n_eff);
  assign cand     = rd_vld ? rd_data : '0;
  assign sum      = {1'b0, best_val} + (lls_pkg::LOAD_W + 1)'(job_time);
  assign sat      = sum[lls_pkg::LOAD_W] ? '1 : sum[lls_pkg::LOAD_W-1:0];

  assign status.has_job    = has_job;
  assign status.batch_last = batch_last;
  assign status.scan_done  = (rd_idx == n_eff) && !rd_pend;
  assign status.out_free   = !out_valid || out_ready;

  // load memory, one read a cycle during the scan
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
    if (cmd.write) begin
      mem[best_idx] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      job_time   <= in_job_time;
      has_job    <= in_has_job;
      batch_last <= in_batch_last;
    end
    if (rd_issue) begin
      rd_idx_d <= rd_idx[IDX_W-1:0];
      rd_vld   <= vld[rd_idx[IDX_W-1:0]];
    end
    if (cmd.capture) begin
      best_val <= '1;
      best_idx <= '0;
    end else if (rd_pend && (cand <= best_val)) begin
      best_val <= cand;
      best_idx <= rd_idx_d;
    end
    if (cmd.finish) begin
      out_completion_time <= max_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= lls_pkg::CFG_W'(1);
      vld          <= '0;
      max_load     <= '0;
      rd_idx       <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        server_count <= cfg_wdata;
      end
      if (cmd.capture) begin
        rd_idx <= '0;
      end else if (rd_issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      rd_pend <= rd_issue;
      if (cmd.finish) begin
        vld      <= '0;
        max_load <= '0;
      end else if (cmd.write) begin
        vld[best_idx] <= 1'b1;
        if (sat > max_load) begin
          max_load <= sat;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (max_load == '0) && (vld == '0))
    else $error("loads not cleared at batch end");
  a_max_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> (max_load >= $past(max_load)) && vld[$past(best_idx)])
    else $error("largest load lost on write");
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (CNT_W'(best_idx) < n_eff))
    else $error("job placed on an unused server");
`endif

endmodule

/* sv/least_loaded_server_dispatch.sv */
`timescale 1ns / 1ps
// channel   dir  fields                              handshake
// job       in   job_time[15:0] has_job batch_last   valid/ready
// result    out  completion_time[31:0]               valid/ready
// cfg       in   cfg_wdata[4:0] (server_count)       cfg_we
//
// a job word makes one load memory read per server in use during the
// least-load scan, then one write back; a word without a job skips both
// batch end loads the result register once it is free; the result there
// may hold while the next word is taken
// reset: server_count 1, all loads zero, no result pending

module least_loaded_server_dispatch #(
  parameter int unsigned MAX_SERVERS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lls_pkg::CFG_W-1:0]  cfg_wdata,
  lls_job_if.sink                    job,
  lls_result_if.source               result
);

  lls_pkg::cmd_t    cmd;
  lls_pkg::status_t status;

  lls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job.valid),
    .job_ready (job.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lls_datapath #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_job_time         (job.job_time),
    .in_has_job          (job.has_job),
    .in_batch_last       (job.batch_last),
    .out_valid           (result.valid),
    .out_ready           (result.ready),
    .out_completion_time (result.completion_time),
    .cmd                 (cmd),
    .status              (status)
  );

endmodule
